FILE: hw/rtl/spd_pkg.sv
// Package for the point distance sorter: payload structs, queue entry,
// sorter states and register indexes.
// No dependencies.
package spd_pkg;

  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 48;
  localparam int KEY_W       = 52;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      batch_end;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sorted_x;
    logic signed [COORD_W-1:0] sorted_y;
    logic signed [COORD_W-1:0] sorted_z;
    logic                      final_point;
  } point_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord3_t;

  typedef struct packed {
    coord3_t            pt;
    logic               batch_end;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } sort_state_t;

endpackage

FILE: hw/rtl/sort_points_by_distance.sv
// Top level of the point distance sorter: configuration registers and the
// front end, queue and sorter. Depends on spd_pkg, spd_front, spd_queue, spd_sorter.
//
// Points are taken one per cycle while the two key stages and the four-entry
// queue have room; each key is the exact squared distance to the target,
// formed in the difference registers, then the square registers, and summed
// from the square registers as the point is pushed into the queue. The sorter
// inserts one point per cycle into its ordered array of MAX_POINTS cells while
// it is loading. A point with batch_end set, or the point that fills the array,
// closes the batch, which then leaves nearest first at one result per cycle
// while out_ready is high; meanwhile the front end keeps taking points until
// the queue and the last key stage are full, six points at most. Equal
// keys keep their arrival order. Targets are read and written at byte
// addresses 0, 4 and 8 and should be changed only while the block is idle.
module sort_points_by_distance import spd_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  point_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output point_out_t  out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [COORD_W-1:0] target_x_r, target_y_r, target_z_r;
  logic                      cfg_wr;
  logic                      push, pop;
  entry_t                    push_data, pop_data;
  queue_status_t             q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r <= '0;
      target_y_r <= '0;
      target_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TARGET_X: target_x_r <= pwdata[COORD_W-1:0];
        REG_TARGET_Y: target_y_r <= pwdata[COORD_W-1:0];
        REG_TARGET_Z: target_z_r <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TARGET_X: prdata = {8'b0, target_x_r};
      REG_TARGET_Y: prdata = {8'b0, target_y_r};
      REG_TARGET_Z: prdata = {8'b0, target_z_r};
      default:      prdata = '0;
    endcase
  end

  spd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .target_x  (target_x_r),
    .target_y  (target_y_r),
    .target_z  (target_z_r),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  spd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  spd_sorter #(
    .MAX_POINTS (MAX_POINTS)
  ) u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_status.empty),
    .q_pop     (pop),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_final_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.final_point |=> !out_valid)
    else $error("sorter still emitting after the last point of a batch");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_status.full)
    else $error("input stalled while the queue has room");

endmodule

FILE: hw/rtl/spd_front.sv
// Front end: accepts points and computes the squared distance key in two stages.
// Depends on spd_pkg; feeds spd_queue.
module spd_front import spd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  point_in_t                 in_data,
  input  logic signed [COORD_W-1:0] target_x,
  input  logic signed [COORD_W-1:0] target_y,
  input  logic signed [COORD_W-1:0] target_z,
  input  queue_status_t             q_status,
  output logic                      push,
  output entry_t                    push_data
);

  logic                     a_valid_r, a_valid_nxt;
  logic                     b_valid_r, b_valid_nxt;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  coord3_t                  a_pt_r, b_pt_r;
  logic                     a_end_r, b_end_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic signed [2*DIFF_W-1:0] px2, py2, pz2;
  logic                     adv;

  assign adv      = !b_valid_r || !q_status.full;
  assign in_ready = adv;
  assign push     = b_valid_r && !q_status.full;

  always_comb begin
    dx_nxt = {in_data.point_x[COORD_W-1], in_data.point_x} - {target_x[COORD_W-1], target_x};
    dy_nxt = {in_data.point_y[COORD_W-1], in_data.point_y} - {target_y[COORD_W-1], target_y};
    dz_nxt = {in_data.point_z[COORD_W-1], in_data.point_z} - {target_z[COORD_W-1], target_z};
    a_valid_nxt = adv ? in_valid : a_valid_r;
    b_valid_nxt = adv ? a_valid_r : b_valid_r;
  end

  assign px2 = dx_r * dx_r;
  assign py2 = dy_r * dy_r;
  assign pz2 = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      dz_r     <= dz_nxt;
      a_pt_r   <= '{x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};
      a_end_r  <= in_data.batch_end;
      sqx_r    <= px2[SQ_W-1:0];
      sqy_r    <= py2[SQ_W-1:0];
      sqz_r    <= pz2[SQ_W-1:0];
      b_pt_r   <= a_pt_r;
      b_end_r  <= a_end_r;
    end
  end

  always_comb begin
    push_data.pt        = b_pt_r;
    push_data.batch_end = b_end_r;
    push_data.key       = KEY_W'(sqx_r) + KEY_W'(sqy_r) + KEY_W'(sqz_r);
  end

endmodule

FILE: hw/rtl/spd_queue.sv
// Short queue of keyed points between the front end and the sorter.
// Depends on spd_pkg.
module spd_queue import spd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  entry_t        push_data,
  input  logic          pop,
  output entry_t        pop_data,
  output queue_status_t status
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign status.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/spd_sorter.sv
// Back end: parallel insertion array that keeps the batch ordered by key,
// then shifts the batch out nearest first. Depends on spd_pkg.
module spd_sorter import spd_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  entry_t        q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output point_out_t    out_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  sort_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0] key_r   [MAX_POINTS];
  logic [KEY_W-1:0] key_nxt [MAX_POINTS];
  logic [KEY_W-1:0] up_key  [MAX_POINTS];
  logic [KEY_W-1:0] dn_key  [MAX_POINTS];
  coord3_t          pt_r    [MAX_POINTS];
  coord3_t          pt_nxt  [MAX_POINTS];
  coord3_t          up_pt   [MAX_POINTS];
  coord3_t          dn_pt   [MAX_POINTS];
  logic [MAX_POINTS-1:0] le, prev_le;
  logic             ins, shift;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      le[i] = (CNT_W'(i) < count_r) && (key_r[i] <= q_data.key);
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_le[i] = 1'b1;
      assign up_key[i]  = key_r[i];
      assign up_pt[i]   = pt_r[i];
    end else begin : g_rest
      assign prev_le[i] = le[i-1];
      assign up_key[i]  = key_r[i-1];
      assign up_pt[i]   = pt_r[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_last
      assign dn_key[i] = key_r[i];
      assign dn_pt[i]  = pt_r[i];
    end else begin : g_inner
      assign dn_key[i] = key_r[i+1];
      assign dn_pt[i]  = pt_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      key_nxt[i] = key_r[i];
      pt_nxt[i]  = pt_r[i];
      if (ins) begin
        if (!le[i]) begin
          if (prev_le[i]) begin
            key_nxt[i] = q_data.key;
            pt_nxt[i]  = q_data.pt;
          end else begin
            key_nxt[i] = up_key[i];
            pt_nxt[i]  = up_pt[i];
          end
        end
      end else if (shift) begin
        key_nxt[i] = dn_key[i];
        pt_nxt[i]  = dn_pt[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    q_pop     = 1'b0;
    out_valid = 1'b0;
    ins       = 1'b0;
    shift     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        q_pop = 1'b1;
        if (q_valid) begin
          ins       = 1'b1;
          count_nxt = count_r + 1'b1;
          if (q_data.batch_end || (count_r + 1'b1 == CNT_W'(MAX_POINTS))) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          shift     = 1'b1;
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      key_r[i] <= key_nxt[i];
      pt_r[i]  <= pt_nxt[i];
    end
  end

  always_comb begin
    out_data.sorted_x    = pt_r[0].x;
    out_data.sorted_y    = pt_r[0].y;
    out_data.sorted_z    = pt_r[0].z;
    out_data.final_point = (count_r == CNT_W'(1));
  end

endmodule
